// ===== rtl/gregorian_to_mjd_macros.svh =====
// Assertion macros for the Gregorian date to MJD converter
`ifndef GREGORIAN_TO_MJD_MACROS_SVH
`define GREGORIAN_TO_MJD_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define GTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define GTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define GTM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/gtm_pkg.sv =====
// Shared types, constants and table functions for the Gregorian date to MJD converter
`default_nettype none

package gtm_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MJD_W   = 25;
    localparam int STAT_W  = 2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_YEAR  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_MONTH = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_DAY   = 2'd3;

    localparam logic signed [YEAR_W-1:0] YEAR_MIN = -16'sd4699;

    // Day and time constants
    localparam logic [17:0] SECS_PER_DAY = 18'd86400;
    localparam logic [17:0] SHIFT_SECS   = 18'd25920;
    localparam logic signed [25:0] MJD_OFFSET = 26'sd2399904;

    // Per-request date result passed between the calc stages
    typedef struct packed {
        logic signed [MJD_W-1:0] mjd;
        logic [STAT_W-1:0]       status;
    } t_date_res;

    // Floor of x/100 by reciprocal multiply; exact for x below 43690
    function automatic logic [9:0] div100(input logic [15:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd5243;
        return p[28:19];
    endfunction

    // Days in month, February without leap day
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        case (m)
            4'd2:                      month_len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    // (306*((m+9)%12)+5)/10 for months 1..12
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    month_offset = 9'd306;
            4'd2:    month_offset = 9'd337;
            4'd3:    month_offset = 9'd0;
            4'd4:    month_offset = 9'd31;
            4'd5:    month_offset = 9'd61;
            4'd6:    month_offset = 9'd92;
            4'd7:    month_offset = 9'd122;
            4'd8:    month_offset = 9'd153;
            4'd9:    month_offset = 9'd184;
            4'd10:   month_offset = 9'd214;
            4'd11:   month_offset = 9'd245;
            4'd12:   month_offset = 9'd275;
            default: month_offset = 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gtm_date_calc.sv =====
// Date check and whole-day MJD computation
`default_nettype none

module gtm_date_calc import gtm_pkg::*; (
    input  wire logic signed [YEAR_W-1:0] i_year,
    input  wire logic [MONTH_W-1:0]       i_month,
    input  wire logic [DAY_W-1:0]         i_day,
    output t_date_res                     o_res
);

    logic signed [16:0] ysx;
    logic [16:0]        u_sum;
    logic [9:0]         cent_q;
    logic               cent;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               jan_feb;
    logic [16:0]        a_sum;
    logic [16:0]        b_sum;
    logic [26:0]        a_prod;
    logic [24:0]        a_term;
    logic [11:0]        c_prod;
    logic [9:0]         c_term;
    logic signed [25:0] mjd_full;
    logic               bad_year;
    logic               bad_month;
    logic               bad_day;

    assign ysx = {i_year[YEAR_W-1], i_year};

    // Leap rule on year+4800, which keeps the residues and stays positive
    assign u_sum  = 17'(ysx + 17'sd4800);
    assign cent_q = div100(u_sum[15:0]);
    assign cent   = (u_sum[15:0] == 16'(cent_q * 16'd100));
    assign leap   = (i_year[1:0] == 2'b00) && (!cent || (cent_q[1:0] == 2'b00));

    always_comb begin
        len = month_len(i_month);
        if (i_month == 4'd2 && leap) begin
            len = 5'd29;
        end
    end

    // January and February count as months of the previous year
    assign jan_feb = (i_month == 4'd1) || (i_month == 4'd2);
    assign a_sum   = 17'(ysx - 17'(jan_feb) + 17'sd4712);
    assign b_sum   = 17'(ysx - 17'(jan_feb) + 17'sd4900);

    assign a_prod = 27'(a_sum[15:0]) * 27'd1461;
    assign a_term = a_prod[26:2];
    assign c_prod = 12'(div100(b_sum[15:0])) * 12'd3;
    assign c_term = c_prod[11:2];

    assign mjd_full = $signed({1'b0, a_term}) + $signed(26'(month_offset(i_month)))
                    - $signed(26'(c_term)) + $signed(26'(i_day)) - MJD_OFFSET;

    // Status with year before month before day
    assign bad_year  = (i_year < YEAR_MIN);
    assign bad_month = (i_month < 4'd1) || (i_month > 4'd12);
    assign bad_day   = (i_day < 5'd1) || (i_day > len);

    always_comb begin
        o_res.mjd = mjd_full[MJD_W-1:0];
        if (bad_year) begin
            o_res.status = STAT_BAD_YEAR;
            o_res.mjd    = '0;
        end else if (bad_month) begin
            o_res.status = STAT_BAD_MONTH;
            o_res.mjd    = '0;
        end else if (bad_day) begin
            o_res.status = STAT_BAD_DAY;
        end else begin
            o_res.status = STAT_OK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gtm_shift_calc.sv =====
// Shifted day number: MJD plus time of day plus 0.3 day, truncated toward zero
`default_nettype none

module gtm_shift_calc import gtm_pkg::*; (
    input  wire t_date_res            i_res,
    input  wire logic [HOUR_W-1:0]    i_hour,
    input  wire logic [MIN_W-1:0]     i_minute,
    input  wire logic [SEC_W-1:0]     i_second,
    output logic signed [MJD_W-1:0]   o_shifted_day
);

    logic [16:0]        secs;
    logic [17:0]        extra;
    logic               carry;
    logic signed [25:0] floor_day;
    logic               round_up;
    logic signed [25:0] trunc_day;

    // Seconds of day plus the 0.3 day offset; always below two days
    assign secs  = 17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second);
    assign extra = 18'(secs) + SHIFT_SECS;
    assign carry = (extra >= SECS_PER_DAY);

    // Floor, then step toward zero for a negative total that is not whole days
    assign floor_day = 26'({i_res.mjd[MJD_W-1], i_res.mjd}) + $signed(26'(carry));
    assign round_up  = floor_day[25] && (extra != SECS_PER_DAY);
    assign trunc_day = floor_day + $signed(26'(round_up));

    assign o_shifted_day = (i_res.status == STAT_OK) ? trunc_day[MJD_W-1:0] : '1;

endmodule

`default_nettype wire

// ===== rtl/gregorian_to_mjd.sv =====
// Top level: Gregorian date and UTC time to Modified Julian Date converter
// Usage:
//   A request is taken at a rising edge with i_start high and o_busy low.
//   o_busy is always low, so one request can be given every clock cycle.
//   The request is held in an input register; the date check, MJD and
//   shifted-day logic are combinational between that register and the result
//   register. A request passes through the input register, then the result
//   register, and shows on the result ports with o_done high.
//   Throughput is one result per cycle, set by the single calc pass.
//   o_done is a one-cycle strobe; the receiver cannot stall, so every result
//   must be taken in the cycle it is shown.
//   o_status: 0 ok, 1 bad year, 2 bad month, 3 bad day. o_day_number is zero
//   for a bad year or month; o_shifted_day is -1 for any status but ok.
//   Synchronous reset clears the request and result strobes; no request in
//   flight at reset produces a result.
`default_nettype none

`include "gregorian_to_mjd_macros.svh"

module gregorian_to_mjd import gtm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic signed [YEAR_W-1:0] i_year,
    input  wire logic [MONTH_W-1:0]       i_month,
    input  wire logic [DAY_W-1:0]         i_day,
    input  wire logic [HOUR_W-1:0]        i_hour,
    input  wire logic [MIN_W-1:0]         i_minute,
    input  wire logic [SEC_W-1:0]         i_second,
    output logic                          o_done,
    output logic signed [MJD_W-1:0]       o_day_number,
    output logic signed [MJD_W-1:0]       o_shifted_day,
    output logic [STAT_W-1:0]             o_status
);

    logic                      r_in_vld;
    logic signed [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0]        r_month;
    logic [DAY_W-1:0]          r_day;
    logic [HOUR_W-1:0]         r_hour;
    logic [MIN_W-1:0]          r_minute;
    logic [SEC_W-1:0]          r_second;

    logic                      r_done;
    logic signed [MJD_W-1:0]   r_day_number;
    logic signed [MJD_W-1:0]   r_shifted_day;
    logic [STAT_W-1:0]         r_status;

    t_date_res                 date_res;
    logic signed [MJD_W-1:0]   n_shifted_day;
    logic                      accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
        if (accept) begin
            r_year   <= i_year;
            r_month  <= i_month;
            r_day    <= i_day;
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
        end
    end

    // Calc pass
    gtm_date_calc u_date (
        .i_year  (r_year),
        .i_month (r_month),
        .i_day   (r_day),
        .o_res   (date_res)
    );

    gtm_shift_calc u_shift (
        .i_res         (date_res),
        .i_hour        (r_hour),
        .i_minute      (r_minute),
        .i_second      (r_second),
        .o_shifted_day (n_shifted_day)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
        if (r_in_vld) begin
            r_day_number  <= date_res.mjd;
            r_shifted_day <= n_shifted_day;
            r_status      <= date_res.status;
        end
    end

    assign o_done        = r_done;
    assign o_day_number  = r_day_number;
    assign o_shifted_day = r_shifted_day;
    assign o_status      = r_status;

    // Checks
    `GTM_ASSERT_NEXT(a_req_in_flight, i_clk, i_rst_n, accept, r_in_vld)
    `GTM_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_in_vld, o_done)
    `GTM_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !r_in_vld, !o_done)
    `GTM_ASSERT_IMPL(a_bad_shift, i_clk, i_rst_n, o_done && (o_status != STAT_OK), o_shifted_day == -25'sd1)
    `GTM_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_done && ((o_status == STAT_BAD_YEAR) || (o_status == STAT_BAD_MONTH)), o_day_number == 25'sd0)

endmodule

`default_nettype wire

// ===== sim/gregorian_to_mjd_test.sv =====
// Self-checking testbench for the Gregorian date to MJD converter
`timescale 1ns / 100ps

module gregorian_to_mjd_test;
    import gtm_pkg::*;

    localparam longint DAY_SECONDS   = 86400;
    localparam longint SHIFT_SECONDS = 25920;
    localparam int     RANDOM_PER_PHASE = 217;
    localparam int     DRAIN_LIMIT   = 1000;

    // One date/time request as driven on the input ports
    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
    } t_date_request;

    // One conversion result as seen on the output ports
    typedef struct packed {
        logic signed [MJD_W-1:0] day_number;
        logic signed [MJD_W-1:0] shifted_day;
        logic [STAT_W-1:0]       status;
    } t_conversion;

    // Directed row: typed marks a hand-written expectation
    typedef struct packed {
        t_date_request req;
        logic          typed;
        t_conversion   want;
    } t_directed_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic signed [YEAR_W-1:0] i_year;
    logic [MONTH_W-1:0]       i_month;
    logic [DAY_W-1:0]         i_day;
    logic [HOUR_W-1:0]        i_hour;
    logic [MIN_W-1:0]         i_minute;
    logic [SEC_W-1:0]         i_second;
    logic                     o_done;
    logic signed [MJD_W-1:0]  o_day_number;
    logic signed [MJD_W-1:0]  o_shifted_day;
    logic [STAT_W-1:0]        o_status;

    t_conversion   pending_conversions[$];
    t_directed_row directed_rows[$];
    int            error_count = 0;
    int            sender_idle_pct = 0;

    gregorian_to_mjd u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .o_done        (o_done),
        .o_day_number  (o_day_number),
        .o_shifted_day (o_shifted_day),
        .o_status      (o_status)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("gregorian_to_mjd: mismatch");
        $finish;
    end

    // Month length with the 4/100/400 leap rule; 0 for an invalid month
    function automatic int days_in_month(input longint year, input int month);
        logic leap;
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        case (month)
            2:              return leap ? 29 : 28;
            4, 6, 9, 11:    return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:        return 0;
        endcase
    endfunction

    // Expected status, MJD at 0h and shifted day for one request
    function automatic t_conversion predict_conversion(input t_date_request r);
        longint      y;
        longint      m;
        longint      d;
        longint      ya;
        longint      mjd;
        longint      total;
        longint      shifted;
        t_conversion res;
        y = r.year;
        m = r.month;
        d = r.day;
        res.day_number  = '0;
        res.shifted_day = '1;
        if (y < YEAR_MIN) begin
            res.status = STAT_BAD_YEAR;
        end else if (m < 1 || m > 12) begin
            res.status = STAT_BAD_MONTH;
        end else begin
            res.status = (d < 1 || d > days_in_month(y, int'(m))) ? STAT_BAD_DAY : STAT_OK;
            ya  = y - (12 - m) / 10;
            mjd = (1461 * (ya + 4712)) / 4 + (306 * ((m + 9) % 12) + 5) / 10
                - (3 * ((ya + 4900) / 100)) / 4 + d - 2399904;
            res.day_number = mjd[MJD_W-1:0];
            if (res.status == STAT_OK) begin
                // time of day is taken unchecked; division truncates toward zero
                total = mjd * DAY_SECONDS + longint'(r.hour) * 3600
                      + longint'(r.minute) * 60 + longint'(r.second) + SHIFT_SECONDS;
                shifted = total / DAY_SECONDS;
                res.shifted_day = shifted[MJD_W-1:0];
            end
        end
        return res;
    endfunction

    // Random request: mostly well-formed dates, some bad days, some raw noise
    function automatic t_date_request random_request();
        t_date_request r;
        int            pick;
        int            dim;
        pick = $urandom_range(99);
        if (pick < 20) begin
            r = t_date_request'({$urandom, $urandom});
        end else begin
            case ($urandom_range(9))
                0, 1:    r.year = $urandom_range(1800, 2200);
                2, 3:    r.year = int'($urandom_range(120)) - 4699;
                4:       r.year = int'($urandom_range(800)) - 400;
                default: r.year = int'($urandom_range(32767 + 4699)) - 4699;
            endcase
            r.month  = $urandom_range(1, 12);
            dim      = days_in_month(r.year, int'(r.month));
            r.day    = $urandom_range(1, dim);
            r.hour   = $urandom_range(23);
            r.minute = $urandom_range(59);
            r.second = $urandom_range(60);
            // just past either end of the month
            if (pick < 32) r.day = ($urandom_range(1) != 0) ? 5'(dim + 1) : 5'd0;
        end
        return r;
    endfunction

    // Drive one request, with random idle cycles ahead of it, until accepted
    task automatic issue_request(input t_date_request r, input logic typed,
                                 input t_conversion want);
        while (int'($urandom_range(99)) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_year   <= r.year;
        i_month  <= r.month;
        i_day    <= r.day;
        i_hour   <= r.hour;
        i_minute <= r.minute;
        i_second <= r.second;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_conversions.push_back(typed ? want : predict_conversion(r));
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_conversion exp_res;
        if (i_rst_n && o_done) begin
            if (pending_conversions.size() == 0) begin
                $error("result with no request pending");
                error_count++;
            end else begin
                exp_res = pending_conversions.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    error_count++;
                end
                if (o_day_number !== exp_res.day_number) begin
                    $error("day_number: expected %0d, got %0d",
                           exp_res.day_number, o_day_number);
                    error_count++;
                end
                if (o_shifted_day !== exp_res.shifted_day) begin
                    $error("shifted_day: expected %0d, got %0d",
                           exp_res.shifted_day, o_shifted_day);
                    error_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_conversion none;
        int          drain;
        none = '0;
        i_rst_n  <= 1'b0;
        i_start  <= 1'b0;
        i_year   <= '0;
        i_month  <= '0;
        i_day    <= '0;
        i_hour   <= '0;
        i_minute <= '0;
        i_second <= '0;

        // epoch, J2000 day, bad year/month codes typed in; the rest predicted
        directed_rows.push_back('{'{16'sd1858, 4'd11, 5'd17, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd0, 25'sd0, STAT_OK}});
        directed_rows.push_back('{'{16'sd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd51544, 25'sd51544, STAT_OK}});
        directed_rows.push_back('{'{-16'sd4700, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd0, -25'sd1, STAT_BAD_YEAR}});
        directed_rows.push_back('{'{-16'sd32768, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63}, 1'b1,
                                  '{25'sd0, -25'sd1, STAT_BAD_YEAR}});
        directed_rows.push_back('{'{16'sd2000, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd0, -25'sd1, STAT_BAD_MONTH}});
        directed_rows.push_back('{'{16'sd2000, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd0, -25'sd1, STAT_BAD_MONTH}});
        directed_rows.push_back('{'{16'sd32767, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0}, 1'b1,
                                  '{25'sd0, -25'sd1, STAT_BAD_MONTH}});
        // lowest legal year and the top of the year range
        directed_rows.push_back('{'{-16'sd4699, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{-16'sd4699, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}, 1'b0, none});
        directed_rows.push_back('{'{16'sd32767, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b0, none});
        // leap rule: by 400, by 100, by 4, not leap, negative years
        directed_rows.push_back('{'{16'sd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd2004, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd2001, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{-16'sd4, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{-16'sd100, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{-16'sd400, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        // day check: zero, past a 30-day month, and end of a 31-day month
        directed_rows.push_back('{'{16'sd2000, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd2000, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd2000, 4'd1, 5'd31, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        // time fields beyond their ranges, taken as given
        directed_rows.push_back('{'{16'sd2020, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63}, 1'b0, none});
        // days just before the epoch; negative sums truncate toward zero
        directed_rows.push_back('{'{16'sd1858, 4'd11, 5'd16, 5'd23, 6'd59, 6'd59}, 1'b0, none});
        directed_rows.push_back('{'{16'sd1858, 4'd11, 5'd16, 5'd0, 6'd0, 6'd0}, 1'b0, none});
        directed_rows.push_back('{'{16'sd1858, 4'd11, 5'd15, 5'd0, 6'd0, 6'd0}, 1'b0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back
        foreach (directed_rows[i])
            issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // random phases: no gaps, heavy gaps, moderate gaps
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 45;
                default: sender_idle_pct = 26;
            endcase
            repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, none);
        end
        i_start <= 1'b0;

        // drain the pipeline
        drain = 0;
        while (pending_conversions.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_conversions.size() != 0) begin
            $error("%0d results never arrived", pending_conversions.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("gregorian_to_mjd: match");
        end else begin
            $display("gregorian_to_mjd: mismatch");
        end
        $finish;
    end

endmodule
